FILE: hw/rtl/page_read_cache_lru_core_defines.svh
// Assertion macros for the page read cache core
`ifndef PAGE_READ_CACHE_LRU_CORE_DEFINES_SVH
`define PAGE_READ_CACHE_LRU_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PRC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PRC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRC_ASSERT(label, clk, rst, prop, msg)
`define PRC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/prc_pkg.sv
// Shared types and constants for the page read cache core
package prc_pkg;
  localparam int DEF_ENTRIES = 8;
  localparam int TAG_W = 40;
  localparam int TIME_W = 48;
  localparam int STAMP_W = 64;

  typedef enum logic [1:0] {
    OP_LOOKUP   = 2'd0,
    OP_FILL     = 2'd1,
    OP_INV_PAGE = 2'd2,
    OP_INV_BLK  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [TAG_W-1:0]   tag;
    logic [TIME_W-1:0]  tval;
    logic [STAMP_W-1:0] stamp;
  } req_t;

  typedef struct packed {
    logic               valid;
    logic               match;
    logic               ready;
    logic [STAMP_W-1:0] stamp;
  } cell_stat_t;
endpackage

FILE: hw/rtl/prc_cell.sv
// One cache entry with tag compare and update logic
module prc_cell
  import prc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  logic       wr_en,
  input  logic       inv_en,
  input  logic       touch_en,
  output cell_stat_t stat
);
  logic               valid;
  logic [TAG_W-1:0]   tag;
  logic [TIME_W-1:0]  ready_time;
  logic [STAMP_W-1:0] stamp;
  logic               pg_match;
  logic               blk_match;

  assign pg_match  = (tag[31:0] == req.tag[31:0]);
  assign blk_match = (tag[31:10] == req.tag[31:10]);

  always_comb begin
    stat.valid = valid;
    stat.match = valid && (tag == req.tag);
    stat.ready = (ready_time <= req.tval);
    stat.stamp = stamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_en) begin
      valid <= 1'b1;
    end else if (inv_en && ((req.op == OP_INV_PAGE && pg_match) ||
                            (req.op == OP_INV_BLK && blk_match))) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag        <= req.tag;
      ready_time <= req.tval;
      stamp      <= req.stamp;
    end else if (touch_en) begin
      stamp      <= req.stamp;
    end
  end
endmodule

FILE: hw/rtl/page_read_cache_lru_core.sv
// Top level of the page read cache core: a row of tag cells with LRU fill
// An accepted start sets pend, and pend in turn registers the result strobe.
// A start is not taken while busy; busy is high for the cycle after start.
// The request is registered; with pend high, all cells compare in parallel and update.
// Reset clears all valid bits and the use clock; entry payloads are not reset.
`include "page_read_cache_lru_core_defines.svh"
module page_read_cache_lru_core
  import prc_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [2:0]  stack_id,
  input  logic [3:0]  die_id,
  input  logic [2:0]  plane_id,
  input  logic [11:0] block_id,
  input  logic [9:0]  page_id,
  input  logic [7:0]  generation,
  input  logic [47:0] time_value,
  output logic        strobe,
  output logic        hit,
  output logic        evicted
);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  req_t               req;
  logic               pend;
  logic [STAMP_W-1:0] use_clock;
  cell_stat_t         stat [ENTRIES];
  logic [ENTRIES-1:0] wr_en;
  logic [ENTRIES-1:0] touch_en;
  logic               hit_c;
  logic               evict_c;
  logic               bump;

  assign busy = pend;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req.op    <= op;
      req.tag   <= {generation, stack_id, die_id, plane_id, block_id, page_id};
      req.tval  <= time_value;
      req.stamp <= use_clock + STAMP_W'(1);
    end
  end

  always_comb begin
    logic             found;
    logic [IDX_W-1:0] vic;
    logic             have;
    logic             done;
    found    = 1'b0;
    vic      = '0;
    have     = 1'b0;
    done     = 1'b0;
    wr_en    = '0;
    touch_en = '0;
    hit_c    = 1'b0;
    evict_c  = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && stat[i].match && stat[i].ready) begin
        found = 1'b1;
        touch_en[i] = pend && (req.op == OP_LOOKUP);
      end
      if (!done) begin
        if (!stat[i].valid || stat[i].match) begin
          vic  = IDX_W'(i);
          done = 1'b1;
        end else if (!have || stat[i].stamp < stat[vic].stamp) begin
          vic  = IDX_W'(i);
          have = 1'b1;
        end
      end
    end
    if (pend && req.op == OP_LOOKUP) hit_c = found;
    if (pend && req.op == OP_FILL) begin
      wr_en[vic] = 1'b1;
      evict_c    = stat[vic].valid;
    end
  end

  assign bump = hit_c || (pend && req.op == OP_FILL);

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    prc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .req      (req),
      .wr_en    (wr_en[g]),
      .inv_en   (pend),
      .touch_en (touch_en[g]),
      .stat     (stat[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      strobe    <= 1'b0;
      use_clock <= '0;
    end else begin
      pend   <= start && !busy;
      strobe <= pend;
      if (bump) use_clock <= req.stamp;
    end
  end

  always_ff @(posedge clk) begin
    hit     <= hit_c;
    evicted <= evict_c;
  end

  `PRC_ASSERT(a_strobe_follows, clk, rst, pend |=> strobe, "result strobe missing")
  `PRC_ASSERT(a_one_write, clk, rst, $onehot0(wr_en), "fill wrote several cells")
  `PRC_ASSERT(a_one_touch, clk, rst, $onehot0(touch_en), "lookup refreshed several cells")
  `PRC_ASSERT(a_no_both, clk, rst, strobe |-> !(hit && evicted), "hit and evicted together")
  `PRC_ASSERT_NR(a_rst_idle, clk, rst |=> !pend && !strobe, "control not cleared by reset")
endmodule
